>>> hdl/wwgs_pkg.sv
// Shared types and constants for the Wireworld generation step.
// No dependencies; every other file of the block except wwgs_ram refers to it by scoped names.
package wwgs_pkg;

  // Default sizes of the line stores and of the row counter.
  localparam int unsigned MAX_COLS_DEF = 1024;
  localparam int unsigned MAX_ROWS_DEF = 4096;

  // Configuration register widths and reset values.
  localparam int unsigned GRID_WIDTH_BITS  = 11;
  localparam int unsigned GRID_HEIGHT_BITS = 13;
  localparam int unsigned CFG_DATA_BITS    = 13;
  localparam int unsigned GRID_WIDTH_RST   = 631;
  localparam int unsigned GRID_HEIGHT_RST  = 958;
  localparam int unsigned GRID_MIN         = 3;

  // Cell coding on the stream.
  localparam int unsigned CELL_BITS = 2;
  typedef enum logic [CELL_BITS-1:0] {
    CELL_BLANK = 2'd0,
    CELL_HEAD  = 2'd1,
    CELL_TAIL  = 2'd2,
    CELL_WIRE  = 2'd3
  } cell_e;

  // Register indexes on the configuration port.
  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-item tag worked out from the raster position at accept time.
  typedef struct packed {
    logic filled;  // window has filled since the last restart
    logic inner;   // incoming cell is at row >= 2 and column >= 2
    logic last;    // result is the bottom-right cell of a frame
  } item_tag_t;

endpackage

>>> hdl/wwgs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module wwgs_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/wwgs_scan.sv
// Raster position, fill count and grid size registers for the Wireworld step.
// Depends on wwgs_pkg for register indexes, widths and the item tag type.
module wwgs_scan #(
  parameter int unsigned MAX_COLS = wwgs_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = wwgs_pkg::MAX_ROWS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [wwgs_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  input  logic                                  step_i,
  output logic [$clog2(MAX_COLS)-1:0]           col_o,
  output wwgs_pkg::item_tag_t                   tag_o
);

  localparam int unsigned CB = $clog2(MAX_COLS);
  localparam int unsigned RB = $clog2(MAX_ROWS);
  localparam int unsigned WB = $clog2(MAX_COLS + 1);
  localparam int unsigned HB = $clog2(MAX_ROWS + 1);
  localparam int unsigned FB = $clog2(MAX_COLS + 2);

  localparam int unsigned WIDTH_RST =
    (wwgs_pkg::GRID_WIDTH_RST < wwgs_pkg::GRID_MIN) ? wwgs_pkg::GRID_MIN :
    (wwgs_pkg::GRID_WIDTH_RST > MAX_COLS) ? MAX_COLS : wwgs_pkg::GRID_WIDTH_RST;
  localparam int unsigned HEIGHT_RST =
    (wwgs_pkg::GRID_HEIGHT_RST < wwgs_pkg::GRID_MIN) ? wwgs_pkg::GRID_MIN :
    (wwgs_pkg::GRID_HEIGHT_RST > MAX_ROWS) ? MAX_ROWS : wwgs_pkg::GRID_HEIGHT_RST;

  logic [WB-1:0] width_q,  width_d;
  logic [HB-1:0] height_q, height_d;
  logic [CB-1:0] col_q,    col_d;
  logic [RB-1:0] row_q,    row_d;
  logic [FB-1:0] fill_q,   fill_d;

  logic [wwgs_pkg::GRID_WIDTH_BITS-1:0]  wr_width;
  logic [wwgs_pkg::GRID_HEIGHT_BITS-1:0] wr_height;
  logic [FB-1:0]                         fill_full;
  logic                                  row_end;
  logic                                  frame_end;

  assign wr_width  = cfg_data_i[wwgs_pkg::GRID_WIDTH_BITS-1:0];
  assign wr_height = cfg_data_i[wwgs_pkg::GRID_HEIGHT_BITS-1:0];

  assign fill_full = FB'(width_q) + FB'(1);
  assign row_end   = (WB'(col_q) + WB'(1)) == width_q;
  assign frame_end = (HB'(row_q) + HB'(1)) == height_q;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    fill_d   = fill_q;
    if (cfg_we_i) begin
      // Clamp the written size into range and restart the stream.
      case (cfg_idx_i)
        wwgs_pkg::REG_GRID_WIDTH: begin
          if (32'(wr_width) < 32'(wwgs_pkg::GRID_MIN)) begin
            width_d = WB'(wwgs_pkg::GRID_MIN);
          end else if (32'(wr_width) > 32'(MAX_COLS)) begin
            width_d = WB'(MAX_COLS);
          end else begin
            width_d = WB'(wr_width);
          end
        end
        wwgs_pkg::REG_GRID_HEIGHT: begin
          if (32'(wr_height) < 32'(wwgs_pkg::GRID_MIN)) begin
            height_d = HB'(wwgs_pkg::GRID_MIN);
          end else if (32'(wr_height) > 32'(MAX_ROWS)) begin
            height_d = HB'(MAX_ROWS);
          end else begin
            height_d = HB'(wr_height);
          end
        end
        default: begin
          width_d = width_q;
        end
      endcase
      col_d  = '0;
      row_d  = '0;
      fill_d = '0;
    end else if (step_i) begin
      if (fill_q < fill_full) begin
        fill_d = fill_q + FB'(1);
      end
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + RB'(1);
      end else begin
        col_d = col_q + CB'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WB'(WIDTH_RST);
      height_q <= HB'(HEIGHT_RST);
      col_q    <= '0;
      row_q    <= '0;
      fill_q   <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
      fill_q   <= fill_d;
    end
  end

  assign col_o        = col_q;
  assign tag_o.filled = fill_q >= fill_full;
  assign tag_o.inner  = (row_q >= RB'(2)) && (col_q >= CB'(2));
  assign tag_o.last   = (fill_q >= fill_full) && (row_q == RB'(1)) && (col_q == '0);

endmodule

>>> hdl/wwgs_window.sv
// 3x3 neighbour window and the Wireworld next-state rule.
// Depends on wwgs_pkg for the cell coding.
module wwgs_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           shift_i,
  input  logic [wwgs_pkg::CELL_BITS-1:0] top_i,
  input  logic [wwgs_pkg::CELL_BITS-1:0] mid_i,
  input  logic [wwgs_pkg::CELL_BITS-1:0] bot_i,
  output logic [wwgs_pkg::CELL_BITS-1:0] next_o
);

  typedef logic [2:0][2:0][wwgs_pkg::CELL_BITS-1:0] win_t;

  win_t win_q, win_d;

  function automatic logic [wwgs_pkg::CELL_BITS-1:0] wire_rule(input win_t win);
    logic [3:0] heads;
    logic [wwgs_pkg::CELL_BITS-1:0] res;
    heads = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1) && win[i][j] == wwgs_pkg::CELL_HEAD) begin
          heads = heads + 4'd1;
        end
      end
    end
    case (win[1][1])
      wwgs_pkg::CELL_HEAD: res = wwgs_pkg::CELL_TAIL;
      wwgs_pkg::CELL_TAIL: res = wwgs_pkg::CELL_WIRE;
      wwgs_pkg::CELL_WIRE: begin
        res = (heads == 4'd1 || heads == 4'd2) ? wwgs_pkg::CELL_HEAD : wwgs_pkg::CELL_WIRE;
      end
      default: res = wwgs_pkg::CELL_BLANK;
    endcase
    return res;
  endfunction

  // Shift left one column; new right column: line stores over the input cell.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = top_i;
    win_d[1][2] = mid_i;
    win_d[2][2] = bot_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

  assign next_o = wire_rule(win_d);

endmodule

>>> hdl/wireworld_generation_step.sv
// Top level of the streaming Wireworld generation step.
// Depends on wwgs_pkg, wwgs_ram, wwgs_scan and wwgs_window.
//
// Cells of a grid_height x grid_width frame enter one per beat in raster order, and every
// input beat gives exactly one result beat: the next-generation value of the cell
// grid_width+1 raster positions behind, so feed grid_width+1 further cells to drain a frame.
// out_valid stays low until the window has first filled after reset or after a configuration
// write; border cells, blank cells and results during first fill come out blank, and
// frame_last marks the bottom-right cell of a frame. One cell is taken every clock unless
// the result side stalls: the block is a two-stage pipeline (input stage, then output
// register), and the single read port of the line-store RAM, one read per cell, sets that
// rate. Both line stores share one RAM word per column (upper line in the high bits, middle
// line in the low bits); the word is read when a cell is accepted and rewritten as the cell
// leaves the input stage. The RAM needs no clearing pass after reset: every entry behind a
// non-border result is rewritten within the current stream before it is read. A write to
// either size register takes effect at once and restarts the raster position and the fill
// count; write only while the block is idle. Sizes below 3 act as 3, sizes above MAX_COLS
// or MAX_ROWS act as those limits; the width takes only the low GRID_WIDTH_BITS data bits.
module wireworld_generation_step #(
  parameter int unsigned MAX_COLS = wwgs_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_ROWS = wwgs_pkg::MAX_ROWS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [wwgs_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // input cells
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [wwgs_pkg::CELL_BITS-1:0]     cell_state_i,
  // results
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output logic [wwgs_pkg::CELL_BITS-1:0]     new_state_o,
  output logic                               out_valid_o,
  output logic                               frame_last_o
);

  localparam int unsigned CB     = $clog2(MAX_COLS);
  localparam int unsigned LINE_W = 2 * wwgs_pkg::CELL_BITS;

  // Handshake and stage control.
  logic accept;
  logic s1_go;

  // Input stage.
  logic                           s1_vld_q,  s1_vld_d;
  logic [wwgs_pkg::CELL_BITS-1:0] s1_cell_q;
  logic [CB-1:0]                  s1_addr_q;
  wwgs_pkg::item_tag_t            s1_tag_q;

  // Output register.
  logic                           res_vld_q, res_vld_d;
  logic [wwgs_pkg::CELL_BITS-1:0] new_state_q;
  logic                           out_valid_q;
  logic                           frame_last_q;

  // Position tracking and line stores.
  logic [CB-1:0]                  col;
  wwgs_pkg::item_tag_t            tag;
  logic [LINE_W-1:0]              line_rdata;
  logic [LINE_W-1:0]              line_wdata;
  logic [wwgs_pkg::CELL_BITS-1:0] line_top;
  logic [wwgs_pkg::CELL_BITS-1:0] line_mid;
  logic [wwgs_pkg::CELL_BITS-1:0] next_cell;

  // Advance the input stage whenever the output register is free or being emptied.
  assign s1_go      = s1_vld_q && (!res_vld_q || res_ready_i);
  assign in_ready_o = !s1_vld_q || s1_go;
  assign accept     = in_valid_i && in_ready_o;

  wwgs_scan #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (accept),
    .col_o      (col),
    .tag_o      (tag)
  );

  // Read the column on accept; rewrite it as the cell leaves the input stage:
  // the old middle line drops into the upper line and the new cell becomes the middle line.
  assign line_top   = line_rdata[LINE_W-1:wwgs_pkg::CELL_BITS];
  assign line_mid   = line_rdata[wwgs_pkg::CELL_BITS-1:0];
  assign line_wdata = {line_mid, s1_cell_q};

  wwgs_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLS)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wdata),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (line_rdata)
  );

  wwgs_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (s1_go),
    .top_i   (line_top),
    .mid_i   (line_mid),
    .bot_i   (s1_cell_q),
    .next_o  (next_cell)
  );

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (s1_go) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    res_vld_d = res_vld_q;
    if (s1_go) begin
      res_vld_d = 1'b1;
    end else if (res_ready_i) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Hold the input beat and its tag while the RAM read is in flight.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cell_q <= cell_state_i;
      s1_addr_q <= col;
      s1_tag_q  <= tag;
    end
  end

  // Blank the result during first fill and on border centres.
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      new_state_q  <= (s1_tag_q.filled && s1_tag_q.inner) ? next_cell
                                                           : wwgs_pkg::CELL_BLANK;
      out_valid_q  <= s1_tag_q.filled;
      frame_last_q <= s1_tag_q.last;
    end
  end

  assign res_valid_o  = res_vld_q;
  assign new_state_o  = new_state_q;
  assign out_valid_o  = out_valid_q;
  assign frame_last_o = frame_last_q;

`ifndef SYNTHESIS
  // A stalled input side means both stages are full and the result is not being taken.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_vld_q && res_vld_q && !res_ready_i))
    else $error("input stalled with room in the pipeline");

  // The RAM write of one cell never lands on the column being read for the next.
  a_no_line_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s1_go) |-> (col != s1_addr_q))
    else $error("line store read and write hit the same column");

  // Only a filled window may give a non-blank cell or a frame end.
  a_blank_before_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !out_valid_q) |-> (new_state_q == wwgs_pkg::CELL_BLANK && !frame_last_q))
    else $error("result during first fill is not blank");

  // A result beat is left in place until it is taken.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_ready_i) |=> (res_vld_q && $stable(new_state_q)))
    else $error("pending result changed before it was taken");
`endif

endmodule

>>> dv/wireworld_generation_step_tb.sv
// Self-checking testbench for wireworld_generation_step: raster cell beats in, one result beat out.
// Depends on wwgs_pkg and the block's RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module wireworld_generation_step_tb;

  localparam int unsigned LINE_DEPTH = wwgs_pkg::MAX_COLS_DEF;
  localparam int unsigned ROW_LIMIT  = wwgs_pkg::MAX_ROWS_DEF;

  // Expected contents of one result beat.
  typedef struct packed {
    wwgs_pkg::cell_e next_cell;
    logic            is_real;
    logic            is_last;
  } gen_result_t;

  // Streaming Wireworld predictor plus the queue of results still owed by the block.
  class generation_tracker;
    logic [wwgs_pkg::GRID_WIDTH_BITS-1:0]  width_reg;
    logic [wwgs_pkg::GRID_HEIGHT_BITS-1:0] height_reg;
    wwgs_pkg::cell_e upper_store [LINE_DEPTH];
    wwgs_pkg::cell_e middle_store [LINE_DEPTH];
    wwgs_pkg::cell_e window [3][3];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned fill_cnt;
    int unsigned error_cnt;
    gen_result_t pending_q[$];

    function new();
      width_reg  = wwgs_pkg::GRID_WIDTH_BITS'(wwgs_pkg::GRID_WIDTH_RST);
      height_reg = wwgs_pkg::GRID_HEIGHT_BITS'(wwgs_pkg::GRID_HEIGHT_RST);
      foreach (upper_store[i]) begin
        upper_store[i]  = wwgs_pkg::CELL_BLANK;
        middle_store[i] = wwgs_pkg::CELL_BLANK;
      end
      foreach (window[i, j]) window[i][j] = wwgs_pkg::CELL_BLANK;
      row_pos   = 0;
      col_pos   = 0;
      fill_cnt  = 0;
      error_cnt = 0;
    endfunction

    // A size write restarts the raster; line stores and window keep their contents.
    function void write_reg(wwgs_pkg::cfg_reg_e idx,
                           logic [wwgs_pkg::CFG_DATA_BITS-1:0] data);
      if (idx == wwgs_pkg::REG_GRID_WIDTH) width_reg = data[wwgs_pkg::GRID_WIDTH_BITS-1:0];
      else height_reg = data[wwgs_pkg::GRID_HEIGHT_BITS-1:0];
      row_pos  = 0;
      col_pos  = 0;
      fill_cnt = 0;
    endfunction

    function int unsigned cols();
      if (width_reg < wwgs_pkg::GRID_MIN) return wwgs_pkg::GRID_MIN;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    function int unsigned rows();
      if (height_reg < wwgs_pkg::GRID_MIN) return wwgs_pkg::GRID_MIN;
      if (height_reg > ROW_LIMIT) return ROW_LIMIT;
      return height_reg;
    endfunction

    function wwgs_pkg::cell_e evolve();
      int unsigned heads;
      heads = 0;
      case (window[1][1])
        wwgs_pkg::CELL_HEAD:  return wwgs_pkg::CELL_TAIL;
        wwgs_pkg::CELL_TAIL:  return wwgs_pkg::CELL_WIRE;
        wwgs_pkg::CELL_BLANK: return wwgs_pkg::CELL_BLANK;
        default: ;
      endcase
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if ((i != 1 || j != 1) && window[i][j] == wwgs_pkg::CELL_HEAD) heads++;
      return (heads == 1 || heads == 2) ? wwgs_pkg::CELL_HEAD : wwgs_pkg::CELL_WIRE;
    endfunction

    function void note_cell(wwgs_pkg::cell_e x);
      int unsigned w, h, c, r;
      wwgs_pkg::cell_e top, mid;
      gen_result_t want;
      w = cols();
      h = rows();
      c = (col_pos >= w) ? 0 : col_pos;
      r = (row_pos >= h) ? 0 : row_pos;
      top = upper_store[c];
      mid = middle_store[c];
      upper_store[c]  = mid;
      middle_store[c] = x;
      for (int i = 0; i < 3; i++) begin
        window[i][0] = window[i][1];
        window[i][1] = window[i][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = x;
      want.is_real   = (fill_cnt >= w + 1);
      want.next_cell = (want.is_real && r >= 2 && c >= 2) ? evolve() : wwgs_pkg::CELL_BLANK;
      want.is_last   = want.is_real && r == 1 && c == 0;
      if (fill_cnt < w + 1) fill_cnt++;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
      pending_q.push_back(want);
    endfunction

    function void check_result(logic [wwgs_pkg::CELL_BITS-1:0] ns, logic ov, logic fl);
      gen_result_t want;
      if (pending_q.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected result beat, new_state %0d out_valid %0d frame_last %0d",
                 $time, ns, ov, fl);
        return;
      end
      want = pending_q.pop_front();
      if (ns !== want.next_cell) begin
        error_cnt++;
        $display("%0t: new_state expected %0d, got %0d", $time, want.next_cell, ns);
      end
      if (ov !== want.is_real) begin
        error_cnt++;
        $display("%0t: out_valid expected %0d, got %0d", $time, want.is_real, ov);
      end
      if (fl !== want.is_last) begin
        error_cnt++;
        $display("%0t: frame_last expected %0d, got %0d", $time, want.is_last, fl);
      end
    endfunction
  endclass

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic                               cfg_idx_i;
  logic [wwgs_pkg::CFG_DATA_BITS-1:0] cfg_data_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [wwgs_pkg::CELL_BITS-1:0]     cell_state_i;
  logic                               res_valid_o;
  logic                               res_ready_i;
  logic [wwgs_pkg::CELL_BITS-1:0]     new_state_o;
  logic                               out_valid_o;
  logic                               frame_last_o;

  generation_tracker tracker;

  // Receiver stall state: a rotating 16-bit mask, re-drawn with a new mode when stall_age runs out.
  logic [15:0] stall_pattern;
  int          stall_mode;
  int          stall_age;

  wireworld_generation_step u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cell_state_i (cell_state_i),
    .res_valid_o  (res_valid_o),
    .res_ready_i  (res_ready_i),
    .new_state_o  (new_state_o),
    .out_valid_o  (out_valid_o),
    .frame_last_o (frame_last_o)
  );

  // 10 ns clock, low phase first after time zero.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver side: change ready on the falling edge only. Mode 0 means no stalls at all for
  // the stretch; otherwise ready follows the rotating mask, so stalls land on every phase.
  always @(negedge clk_i) begin
    if (stall_age == 0) begin
      stall_mode    = $urandom_range(0, 3);
      stall_pattern = 16'($urandom);
      stall_age     = 48;
    end
    stall_age--;
    stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
    res_ready_i   = (stall_mode == 0) ? 1'b1 : stall_pattern[0];
  end

  // Every result beat is checked against the oldest prediction at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i)
      tracker.check_result(new_state_o, out_valid_o, frame_last_o);
  end

  // Present one cell and hold it until the block takes the beat; note it once taken.
  // Valid is left high so a following beat can go out on the very next edge.
  task automatic send_cell(input wwgs_pkg::cell_e c);
    @(negedge clk_i);
    in_valid_i   = 1'b1;
    cell_state_i = c;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_cell(c);
  endtask

  // Drop valid for a number of falling edges.
  task automatic hold_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
  endtask

  // Wire-heavy mix, so that wires next to one or two heads turn up often.
  function automatic wwgs_pkg::cell_e wire_biased_cell();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 20) return wwgs_pkg::CELL_BLANK;
    if (roll < 38) return wwgs_pkg::CELL_HEAD;
    if (roll < 50) return wwgs_pkg::CELL_TAIL;
    return wwgs_pkg::CELL_WIRE;
  endfunction

  // Send n cells in bursts of random length; gap_max of zero gives a gap-free stream.
  task automatic feed_cells(input int unsigned n, input bit noise, input int unsigned gap_max);
    int unsigned burst;
    burst = $urandom_range(1, 24);
    for (int unsigned k = 0; k < n; k++) begin
      send_cell(noise ? wwgs_pkg::cell_e'($urandom_range(0, 3)) : wire_biased_cell());
      burst--;
      if (burst == 0) begin
        if (gap_max > 0) hold_input($urandom_range(0, gap_max));
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  // Idle the sender, let every owed result come back, then allow the two-stage pipe to settle.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Size writes only ever happen with the block idle.
  task automatic write_register(input wwgs_pkg::cfg_reg_e idx,
                                input logic [wwgs_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    // Two 3x3 frames: the first has a wire centre next to one head, the second next to two.
    // Four more cells then drain the second frame through to its bottom-right result.
    wwgs_pkg::cell_e demo_cells [22] = '{
      wwgs_pkg::CELL_TAIL,  wwgs_pkg::CELL_HEAD,  wwgs_pkg::CELL_BLANK,
      wwgs_pkg::CELL_WIRE,  wwgs_pkg::CELL_WIRE,  wwgs_pkg::CELL_WIRE,
      wwgs_pkg::CELL_BLANK, wwgs_pkg::CELL_TAIL,  wwgs_pkg::CELL_WIRE,
      wwgs_pkg::CELL_HEAD,  wwgs_pkg::CELL_BLANK, wwgs_pkg::CELL_HEAD,
      wwgs_pkg::CELL_BLANK, wwgs_pkg::CELL_WIRE,  wwgs_pkg::CELL_TAIL,
      wwgs_pkg::CELL_WIRE,  wwgs_pkg::CELL_BLANK, wwgs_pkg::CELL_WIRE,
      wwgs_pkg::CELL_WIRE,  wwgs_pkg::CELL_WIRE,  wwgs_pkg::CELL_HEAD,  wwgs_pkg::CELL_BLANK
    };
    int unsigned sent;
    int unsigned n;
    int unsigned gap_max;
    bit noise;
    logic [wwgs_pkg::CFG_DATA_BITS-1:0] width_val;
    logic [wwgs_pkg::CFG_DATA_BITS-1:0] height_val;

    tracker      = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = wwgs_pkg::REG_GRID_WIDTH;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    cell_state_i = wwgs_pkg::CELL_BLANK;
    res_ready_i  = 1'b0;
    stall_pattern = '0;
    stall_mode   = 0;
    stall_age    = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset sizes are huge, so these beats all land in the first fill.
    send_cell(wwgs_pkg::CELL_BLANK);
    send_cell(wwgs_pkg::CELL_HEAD);
    send_cell(wwgs_pkg::CELL_TAIL);
    send_cell(wwgs_pkg::CELL_WIRE);
    wait_drained();

    // Sizes below the minimum act as 3x3; all data bits low on the width write.
    write_register(wwgs_pkg::REG_GRID_WIDTH, '0);
    write_register(wwgs_pkg::REG_GRID_HEIGHT, 13'd2);
    foreach (demo_cells[i]) send_cell(demo_cells[i]);
    wait_drained();

    // Random phases: new sizes, then mostly whole frames plus the drain tail, some noise.
    sent = 0;
    while (sent < 440) begin
      case ($urandom_range(0, 15))
        0:       width_val = wwgs_pkg::CFG_DATA_BITS'($urandom_range(0, 2));
        1:       width_val = wwgs_pkg::CFG_DATA_BITS'(
                   ($urandom_range(1, 3) << wwgs_pkg::GRID_WIDTH_BITS) | $urandom_range(3, 12));
        default: width_val = wwgs_pkg::CFG_DATA_BITS'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 15))
        0:       height_val = wwgs_pkg::CFG_DATA_BITS'($urandom_range(0, 2));
        1:       height_val = $urandom_range(0, 1) ? 13'h1fff : 13'($urandom_range(4097, 8191));
        default: height_val = wwgs_pkg::CFG_DATA_BITS'($urandom_range(3, 8));
      endcase
      if ($urandom_range(0, 1)) begin
        write_register(wwgs_pkg::REG_GRID_WIDTH, width_val);
        write_register(wwgs_pkg::REG_GRID_HEIGHT, height_val);
      end else begin
        write_register(wwgs_pkg::REG_GRID_HEIGHT, height_val);
        write_register(wwgs_pkg::REG_GRID_WIDTH, width_val);
      end
      noise   = ($urandom_range(0, 4) == 0);
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (noise) n = $urandom_range(5, 40);
      else if (tracker.rows() > 8) n = $urandom_range(20, 60);
      else n = $urandom_range(1, 3) * tracker.cols() * tracker.rows() + tracker.cols() + 1;
      feed_cells(n, noise, gap_max);
      sent += n;
      wait_drained();
    end

    // One pass at the widest clamp: every width bit high, just past the first fill.
    write_register(wwgs_pkg::REG_GRID_WIDTH, 13'h07ff);
    write_register(wwgs_pkg::REG_GRID_HEIGHT, 13'd3);
    feed_cells(LINE_DEPTH + 6, 1'b0, 2);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (tracker.error_cnt == 0 && tracker.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
